>>> rtl/core/spb_pkg.sv
// shared constants, codes and types of the spawn burst detector
`default_nettype none
package spb_pkg;
  localparam int TRACKED_PARENTS_DEF = 64;
  localparam int WINDOW_MAX_DEF      = 7;
  localparam int ID_W                = 22;
  localparam int TS_W                = 32;
  localparam int MA_W                = 3;
  localparam logic [MA_W-1:0] MA_RESET = 3'd5;
  localparam logic [TS_W-1:0] TF_RESET = 32'd10;

  localparam logic CFG_MAX_ALLOWED = 1'b0;
  localparam logic CFG_TIME_FRAME  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NEW   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_ALARM = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RD,
    ST_FIN,
    ST_EVAL,
    ST_WB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] child;
    logic [TS_W-1:0] stamp;
  } win_entry_t;
endpackage
`default_nettype wire

>>> rtl/core/per_parent_spawn_burst_detector.sv
// top level of the per-parent spawn burst detector
// a request goes through a pipelined scan over every tag memory entry and a decide step; a
//   known parent then reads its window, appends the new entry, evaluates the window and
//   writes it back, and every request ends by emitting its results
// a new request is accepted only in idle, after the last result of the previous one has
//   been loaded into the output register
// reset: synchronous active low, clears valid bits, control state and the registers to
//   max_allowed 5 and time_frame 10; memory contents are not cleared
`default_nettype none
module per_parent_spawn_burst_detector #(
  parameter int TRACKED_PARENTS = spb_pkg::TRACKED_PARENTS_DEF,
  parameter int WINDOW_MAX      = spb_pkg::WINDOW_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // parent_id [21:0], child_id [43:22], timestamp [75:44], zero fill
  input  wire logic [79:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // flagged_child [21:0], zero fill
  output logic      [23:0] out_tdata,
  // status [1:0]
  output logic      [1:0]  out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int ID_W = spb_pkg::ID_W;
  localparam int TS_W = spb_pkg::TS_W;
  localparam int MA_W = spb_pkg::MA_W;
  localparam int SW   = (TRACKED_PARENTS > 1) ? $clog2(TRACKED_PARENTS) : 1;
  localparam int AW   = (TRACKED_PARENTS * WINDOW_MAX > 1) ?
                        $clog2(TRACKED_PARENTS * WINDOW_MAX) : 1;
  localparam int FW   = $clog2(WINDOW_MAX + 1);    // window fill
  localparam int NW   = $clog2(WINDOW_MAX + 2);    // fill plus the new entry
  localparam int BW   = $clog2(WINDOW_MAX + 1);    // buffer index
  localparam int CW   = ((NW > MA_W) ? NW : MA_W) + 1;
  localparam int TW   = FW + ID_W;                 // tag memory word: {fill, tag}
  localparam int EW   = ID_W + TS_W;

  // configuration registers
  logic [MA_W-1:0] ma_r;
  logic [TS_W-1:0] tf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_r <= spb_pkg::MA_RESET;
      tf_r <= spb_pkg::TF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spb_pkg::CFG_MAX_ALLOWED: ma_r <= cfg_data[MA_W-1:0];
        spb_pkg::CFG_TIME_FRAME:  tf_r <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  spb_pkg::state_t state_r, state_nxt;

  logic [ID_W-1:0] pid_r, cid_r;
  logic [TS_W-1:0] ts_r;

  logic [TRACKED_PARENTS-1:0] valid_r, valid_nxt;
  logic [SW-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic            chk_v_r, chk_v_nxt;
  logic [SW-1:0]   chk_i_r, chk_i_nxt;
  logic            found_r, found_nxt;
  logic            free_found_r, free_found_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [SW-1:0]   free_r, free_nxt;
  logic [FW-1:0]   fill_old_r, fill_old_nxt;

  logic [NW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [NW-1:0]   k_r, k_nxt;
  logic            ins_r, ins_nxt;
  logic [TS_W-1:0] last_t_r, last_t_nxt;
  logic            alarm_r, alarm_nxt;
  logic [NW-1:0]   drop_r, drop_nxt;
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [1:0]      status_r, status_nxt;

  spb_pkg::win_entry_t buf_r   [WINDOW_MAX+1];
  spb_pkg::win_entry_t buf_nxt [WINDOW_MAX+1];

  logic            out_v_r, out_v_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic [ID_W-1:0] out_ch_r, out_ch_nxt;
  logic            out_last_r, out_last_nxt;

  // memory ports
  logic            tag_we;
  logic [SW-1:0]   tag_waddr;
  logic [TW-1:0]   tag_wdata;
  logic [TW-1:0]   tag_rdata;
  logic            win_we;
  logic [AW-1:0]   win_waddr;
  logic [EW-1:0]   win_wdata;
  logic [AW-1:0]   win_raddr;
  logic [EW-1:0]   win_rdata;

  spb_ram #(.DEPTH(TRACKED_PARENTS), .DW(TW), .AW(SW)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (scan_cnt_r),
    .rdata (tag_rdata)
  );

  spb_ram #(.DEPTH(TRACKED_PARENTS * WINDOW_MAX), .DW(EW), .AW(AW)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // helpers
  logic             in_acc;
  logic             out_free;
  logic [AW-1:0]    slot_base;
  logic [AW-1:0]    free_base;
  spb_pkg::win_entry_t new_ent;
  spb_pkg::win_entry_t rd_ent;
  spb_pkg::win_entry_t idx_ent;
  logic [CW-1:0]    k_ext, ma_ext, drop_ext, kd_ext;
  logic             over;
  logic             emit_load;
  logic             emit_last;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign slot_base = AW'(slot_r) * AW'(WINDOW_MAX);
  assign free_base = AW'(free_r) * AW'(WINDOW_MAX);
  assign new_ent   = '{child: cid_r, stamp: ts_r};
  assign rd_ent    = spb_pkg::win_entry_t'(win_rdata);
  assign idx_ent   = buf_r[idx_r[BW-1:0]];
  assign k_ext     = CW'(k_r);
  assign ma_ext    = CW'(ma_r);
  assign over      = k_ext > ma_ext;
  assign kd_ext    = k_ext - CW'(WINDOW_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spb_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = spb_pkg::ST_SCAN;
      end
      spb_pkg::ST_SCAN: begin
        if (chk_v_r && chk_i_r == SW'(TRACKED_PARENTS - 1)) state_nxt = spb_pkg::ST_DECIDE;
      end
      spb_pkg::ST_DECIDE: begin
        state_nxt = found_r ? spb_pkg::ST_RD : spb_pkg::ST_EMIT;
      end
      spb_pkg::ST_RD: begin
        if (rd_cnt_r == NW'(fill_old_r) && !pend_r) state_nxt = spb_pkg::ST_FIN;
      end
      spb_pkg::ST_FIN:  state_nxt = spb_pkg::ST_EVAL;
      spb_pkg::ST_EVAL: state_nxt = spb_pkg::ST_WB;
      spb_pkg::ST_WB: begin
        if (idx_r >= k_r) state_nxt = spb_pkg::ST_EMIT;
      end
      spb_pkg::ST_EMIT: begin
        if (emit_load && emit_last) state_nxt = spb_pkg::ST_IDLE;
      end
      default: state_nxt = spb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_nxt      = valid_r;
    scan_cnt_nxt   = scan_cnt_r;
    chk_v_nxt      = chk_v_r;
    chk_i_nxt      = chk_i_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    slot_nxt       = slot_r;
    free_nxt       = free_r;
    fill_old_nxt   = fill_old_r;
    rd_cnt_nxt     = rd_cnt_r;
    pend_nxt       = 1'b0;
    k_nxt          = k_r;
    ins_nxt        = ins_r;
    last_t_nxt     = last_t_r;
    alarm_nxt      = alarm_r;
    drop_nxt       = drop_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    buf_nxt        = buf_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_st_nxt     = out_st_r;
    out_ch_nxt     = out_ch_r;
    out_last_nxt   = out_last_r;
    tag_we         = 1'b0;
    tag_waddr      = slot_r;
    tag_wdata      = {FW'(0), pid_r};
    win_we         = 1'b0;
    win_waddr      = slot_base;
    win_wdata      = new_ent;
    win_raddr      = slot_base + AW'(rd_cnt_r);
    drop_ext       = '0;
    emit_load      = 1'b0;
    emit_last      = 1'b0;
    in_tready      = (state_r == spb_pkg::ST_IDLE);

    case (state_r)
      spb_pkg::ST_IDLE: begin
        scan_cnt_nxt   = '0;
        chk_v_nxt      = 1'b0;
        found_nxt      = 1'b0;
        free_found_nxt = 1'b0;
      end
      spb_pkg::ST_SCAN: begin
        // pipelined walk over the tag memory, compare in the cycle after the read
        scan_cnt_nxt = scan_cnt_r + SW'(1);
        chk_v_nxt    = 1'b1;
        chk_i_nxt    = scan_cnt_r;
        if (chk_v_r) begin
          if (valid_r[chk_i_r]) begin
            if (!found_r && tag_rdata[ID_W-1:0] == pid_r) begin
              found_nxt    = 1'b1;
              slot_nxt     = chk_i_r;
              fill_old_nxt = tag_rdata[TW-1:ID_W];
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = chk_i_r;
          end
        end
      end
      spb_pkg::ST_DECIDE: begin
        alarm_nxt  = 1'b0;
        rd_cnt_nxt = '0;
        k_nxt      = '0;
        ins_nxt    = 1'b0;
        status_nxt = spb_pkg::STAT_OK;
        if (!found_r) begin
          if (free_found_r) begin
            // new parent: one-entry window in the lowest free slot
            tag_we             = 1'b1;
            tag_waddr          = free_r;
            tag_wdata          = {FW'(1), pid_r};
            win_we             = 1'b1;
            win_waddr          = free_base;
            valid_nxt[free_r]  = 1'b1;
            status_nxt         = spb_pkg::STAT_NEW;
          end else begin
            status_nxt = spb_pkg::STAT_FULL;
          end
        end
      end
      spb_pkg::ST_RD: begin
        if (rd_cnt_r < NW'(fill_old_r)) begin
          rd_cnt_nxt = rd_cnt_r + NW'(1);
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          // new entry goes before the first strictly later stamp
          if (!ins_r && rd_ent.stamp > ts_r) begin
            buf_nxt[k_r[BW-1:0]]          = new_ent;
            buf_nxt[k_r[BW-1:0] + BW'(1)] = rd_ent;
            k_nxt   = k_r + NW'(2);
            ins_nxt = 1'b1;
          end else begin
            buf_nxt[k_r[BW-1:0]] = rd_ent;
            k_nxt = k_r + NW'(1);
          end
          last_t_nxt = rd_ent.stamp;
        end
      end
      spb_pkg::ST_FIN: begin
        if (!ins_r) begin
          buf_nxt[k_r[BW-1:0]] = new_ent;
          k_nxt      = k_r + NW'(1);
          last_t_nxt = ts_r;
        end
      end
      spb_pkg::ST_EVAL: begin
        if (over) drop_ext = k_ext - ma_ext;
        if (k_ext - drop_ext > CW'(WINDOW_MAX)) drop_ext = kd_ext;
        alarm_nxt = over && (last_t_r - buf_r[0].stamp <= tf_r);
        drop_nxt  = NW'(drop_ext);
        idx_nxt   = NW'(drop_ext);
      end
      spb_pkg::ST_WB: begin
        if (idx_r < k_r) begin
          win_we    = 1'b1;
          win_waddr = slot_base + AW'(idx_r - drop_r);
          win_wdata = idx_ent;
          idx_nxt   = idx_r + NW'(1);
        end else begin
          tag_we    = 1'b1;
          tag_waddr = slot_r;
          tag_wdata = {FW'(k_r - drop_r), pid_r};
          idx_nxt   = '0;
        end
      end
      spb_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          out_v_nxt = 1'b1;
          if (alarm_r) begin
            emit_last    = (idx_r == k_r - NW'(1));
            out_st_nxt   = spb_pkg::STAT_ALARM;
            out_ch_nxt   = idx_ent.child;
            out_last_nxt = emit_last;
            idx_nxt      = idx_r + NW'(1);
          end else begin
            emit_last    = 1'b1;
            out_st_nxt   = status_r;
            out_ch_nxt   = '0;
            out_last_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spb_pkg::ST_IDLE;
      valid_r <= '0;
      out_v_r <= 1'b0;
      chk_v_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      out_v_r <= out_v_nxt;
      chk_v_r <= chk_v_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pid_r <= in_tdata[ID_W-1:0];
      cid_r <= in_tdata[2*ID_W-1:ID_W];
      ts_r  <= in_tdata[2*ID_W+TS_W-1:2*ID_W];
    end
    scan_cnt_r   <= scan_cnt_nxt;
    chk_i_r      <= chk_i_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    slot_r       <= slot_nxt;
    free_r       <= free_nxt;
    fill_old_r   <= fill_old_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    k_r          <= k_nxt;
    ins_r        <= ins_nxt;
    last_t_r     <= last_t_nxt;
    alarm_r      <= alarm_nxt;
    drop_r       <= drop_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    buf_r        <= buf_nxt;
    out_st_r     <= out_st_nxt;
    out_ch_r     <= out_ch_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_ch_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  // checks
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == spb_pkg::ST_SCAN)
    else $error("request accepted without starting the tag scan");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && emit_last) |=> state_r == spb_pkg::ST_IDLE && out_tlast && out_tvalid)
    else $error("final result did not close the request");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spb_pkg::ST_WB) |-> (CW'(k_r - drop_r) <= CW'(WINDOW_MAX)))
    else $error("window write-back exceeds capacity");

endmodule
`default_nettype wire

>>> rtl/core/spb_ram.sv
// single write port, single read port memory with registered read data
`default_nettype none
module spb_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> verif/per_parent_spawn_burst_detector_tb.sv
// self-checking testbench of the per-parent spawn burst detector
`default_nettype none
module per_parent_spawn_burst_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARENTS = spb_pkg::TRACKED_PARENTS_DEF;
  localparam int WMAX    = spb_pkg::WINDOW_MAX_DEF;
  localparam int ID_W    = spb_pkg::ID_W;
  localparam int TS_W    = spb_pkg::TS_W;
  localparam int MA_W    = spb_pkg::MA_W;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [79:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  per_parent_spawn_burst_detector dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one expected result beat
  typedef struct {
    logic [1:0]      status;
    logic [ID_W-1:0] child;
    logic            last;
  } verdict_t;

  // directed row: event plus optional typed-in expectation of its first beat
  typedef struct {
    logic [ID_W-1:0] parent;
    logic [ID_W-1:0] child;
    logic [TS_W-1:0] stamp;
    bit              typed;
    logic [1:0]      status;
  } spawn_row_t;

  verdict_t verdicts[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;     // no idling in the last part

  // predictor state
  logic [MA_W-1:0] limit_q;
  logic [TS_W-1:0] span_q;
  logic [ID_W-1:0] tag_q[PARENTS];
  bit              live_q[PARENTS];
  int              fill_q[PARENTS];
  logic [ID_W-1:0] kid_q[PARENTS][WMAX];
  logic [TS_W-1:0] when_q[PARENTS][WMAX];

  // append one expected beat at the tail of the queue
  function automatic void queue_verdict(logic [1:0] st, logic [ID_W-1:0] ch, logic lst);
    verdict_t v;
    v.status = st;
    v.child  = ch;
    v.last   = lst;
    verdicts.insert(verdicts.size(), v);
  endfunction

  // walk one spawn event through the window model, queue its verdicts
  function automatic void predict_spawn(logic [ID_W-1:0] pid, logic [ID_W-1:0] cid,
                                        logic [TS_W-1:0] ts);
    int slot, free_slot, n, pos, drop;
    bit alarm;
    logic [ID_W-1:0] wc[WMAX+1];
    logic [TS_W-1:0] wt[WMAX+1];
    slot = -1;
    free_slot = -1;
    alarm = 1'b0;
    drop = 0;
    for (int i = 0; i < PARENTS; i++) begin
      if (live_q[i]) begin
        if (slot < 0 && tag_q[i] == pid) slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (slot < 0) begin
      if (free_slot < 0) begin
        queue_verdict(spb_pkg::STAT_FULL, '0, 1'b1);
      end else begin
        live_q[free_slot] = 1'b1;
        tag_q[free_slot] = pid;
        fill_q[free_slot] = 1;
        kid_q[free_slot][0] = cid;
        when_q[free_slot][0] = ts;
        queue_verdict(spb_pkg::STAT_NEW, '0, 1'b1);
      end
      return;
    end
    n = fill_q[slot];
    pos = 0;
    while (pos < n && when_q[slot][pos] <= ts) pos++;
    for (int j = 0; j < pos; j++) begin
      wc[j] = kid_q[slot][j];
      wt[j] = when_q[slot][j];
    end
    wc[pos] = cid;
    wt[pos] = ts;
    for (int j = pos; j < n; j++) begin
      wc[j+1] = kid_q[slot][j];
      wt[j+1] = when_q[slot][j];
    end
    n++;
    if (n > int'(limit_q)) begin
      if (wt[n-1] - wt[0] <= span_q) begin
        alarm = 1'b1;
        for (int j = 0; j < n; j++)
          queue_verdict(spb_pkg::STAT_ALARM, wc[j], j == n - 1);
      end
      drop = n - int'(limit_q);
    end
    if (n - drop > WMAX) drop = n - WMAX;
    for (int j = drop; j < n; j++) begin
      kid_q[slot][j-drop] = wc[j];
      when_q[slot][j-drop] = wt[j];
    end
    fill_q[slot] = n - drop;
    if (!alarm) queue_verdict(spb_pkg::STAT_OK, '0, 1'b1);
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // send one request, predicting it at acceptance; valid stays up until the next idle
  task automatic send_spawn(logic [ID_W-1:0] pid, logic [ID_W-1:0] cid, logic [TS_W-1:0] ts);
    idle_burst();
    in_tdata <= {4'd0, ts, cid, pid};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_spawn(pid, cid, ts);
  endtask

  // wait until all results are back, then let the block settle before a write
  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (PARENTS + 4 * WMAX + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == spb_pkg::CFG_MAX_ALLOWED) limit_q = val[MA_W-1:0];
    else span_q = val;
    @(posedge clk);
  endtask

  // receiver: bursts of stalls, compare every beat against the oldest verdict
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result: status %0d child %0h", out_tuser, out_tdata[ID_W-1:0]);
          errors++;
        end else begin
          v = verdicts.pop_front();
          if (out_tuser !== v.status) begin
            $error("status: expected %0d actual %0d", v.status, out_tuser);
            errors++;
          end
          if (out_tdata[ID_W-1:0] !== v.child) begin
            $error("flagged_child: expected %0h actual %0h", v.child, out_tdata[ID_W-1:0]);
            errors++;
          end
          if (out_tlast !== v.last) begin
            $error("last: expected %0d actual %0d", v.last, out_tlast);
            errors++;
          end
        end
      end
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("per_parent_spawn_burst_detector_tb: errors");
      $finish;
    end
  end

  // directed rows
  spawn_row_t script[11] = '{
    '{22'd0,        22'h3FFFFF, 32'd0,          1'b1, spb_pkg::STAT_NEW},
    '{22'h3FFFFF,   22'd0,      32'hFFFFFFFF,   1'b1, spb_pkg::STAT_NEW},
    '{22'd0,        22'd1,      32'd0,          1'b1, spb_pkg::STAT_OK},
    '{22'd0,        22'd2,      32'd5,          1'b0, 2'd0},
    '{22'd0,        22'd3,      32'd3,          1'b0, 2'd0},
    '{22'd0,        22'd4,      32'd3,          1'b0, 2'd0},
    '{22'd0,        22'd5,      32'd20,         1'b0, 2'd0},
    '{22'd0,        22'd6,      32'd4,          1'b0, 2'd0},
    '{22'd0,        22'd7,      32'd2,          1'b0, 2'd0},
    '{22'h3FFFFF,   22'h2AAAAA, 32'hFFFFFFF8,   1'b0, 2'd0},
    '{22'h3FFFFF,   22'h155555, 32'hFFFFFFFF,   1'b0, 2'd0}
  };

  initial begin
    logic [ID_W-1:0] pid;
    logic [TS_W-1:0] base;
    int k;
    limit_q = spb_pkg::MA_RESET;
    span_q = spb_pkg::TF_RESET;
    for (int i = 0; i < PARENTS; i++) begin
      live_q[i] = 1'b0;
      fill_q[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset settings: new parent, extremes, bursts, equal stamps
    foreach (script[r]) begin
      send_spawn(script[r].parent, script[r].child, script[r].stamp);
      if (script[r].typed && verdicts[verdicts.size()-1].status !== script[r].status) begin
        $error("status: expected %0d actual %0d", script[r].status,
               verdicts[verdicts.size()-1].status);
        errors++;
      end
    end
    drain();

    // max allowed zero: every insert alarms; widest span
    write_reg(spb_pkg::CFG_MAX_ALLOWED, 32'd0);
    write_reg(spb_pkg::CFG_TIME_FRAME, 32'hFFFFFFFF);
    send_spawn(22'd0, 22'h11, 32'd1);
    send_spawn(22'h3FFFFF, 22'h12, 32'd0);
    drain();

    // largest limit, zero span: window capacity and equal-stamp alarms
    write_reg(spb_pkg::CFG_MAX_ALLOWED, 32'd7);
    write_reg(spb_pkg::CFG_TIME_FRAME, 32'd0);
    for (int j = 0; j < 9; j++) send_spawn(22'h77, 22'h100 + 22'(j), 32'd50);
    drain();

    // fill the parent table, then overflow it
    for (int j = 0; j < PARENTS; j++) send_spawn(22'h200 + 22'(j), 22'h1, 32'd0);
    send_spawn(22'h3FFFFE, 22'h2, 32'd0);
    drain();

    // random phases across several settings; table is full of known parents now,
    // so unseen ids give table-full results while known ids exercise windows
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(spb_pkg::CFG_MAX_ALLOWED, phase == 0 ? 32'd1 : 32'($urandom_range(1, 6)));
      write_reg(spb_pkg::CFG_TIME_FRAME,
                phase == 3 ? 32'hFFFFFFFF : 32'($urandom_range(0, 40)));
      if (phase == 3) quiet = 1'b1;
      for (int j = 0; j < 25; j++) begin
        k = $urandom_range(0, 9);
        if (k == 0) pid = 22'($urandom());
        else if (k == 1) pid = tag_q[$urandom_range(0, PARENTS - 1)];
        else pid = 22'h200 + 22'($urandom_range(0, 5));
        base = (k == 2) ? $urandom() : 32'($urandom_range(0, 60));
        send_spawn(pid, 22'($urandom()), base);
        if (phase == 1 && j == 20) drain();
      end
      drain();
    end

    if (errors == 0 && verdicts.size() == 0) begin
      $display("per_parent_spawn_burst_detector_tb: clean");
    end else begin
      $display("per_parent_spawn_burst_detector_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/core/spb_pkg.sv
rtl/core/spb_ram.sv
rtl/core/per_parent_spawn_burst_detector.sv
verif/per_parent_spawn_burst_detector_tb.sv
